FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/srbp_pkg.sv
package srbp_pkg;

   localparam int FIFO_DEPTH_DEF = 32;
   localparam int OP_W           = 3;
   localparam int BYTE_W         = 8;
   localparam int COUNT_W        = 5;

   localparam logic [OP_W-1:0] OP_RX_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_RX_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_TX_PUSH = 3'd2;
   localparam logic [OP_W-1:0] OP_TX_POP  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   // controller -> datapath strobes
   typedef struct packed {
      logic capture;   // latch request word
      logic execute;   // run the operation on the FIFOs
      logic load;      // fill the response register
   } cmd_type;

endpackage

FILE: rtl/serial_ring_buffer_pair_unit.sv
// UART byte FIFO pair: a receive ring and a transmit ring of FIFO_DEPTH bytes
// each (power of two, one slot kept empty, so FIFO_DEPTH-1 usable). A request
// word carries an op (rx push, rx pop, tx push, tx pop, clear) and a byte; every
// request yields exactly one response word with the popped byte, its valid bit,
// the push accept bit, the receive fill count and the transmit irq flag. tx
// pushes are dropped while csr tx_enabled is low. A request passes the execute
// step (pointer compare, store write and registered store read), then the load
// step that fills the response register once it is free or being drained; a
// new request is taken in the same cycle that the previous response is loaded,
// as long as the response register is free or being drained. No clearing pass
// after reset: pointers reset, stores do not.
module serial_ring_buffer_pair_unit #(
   parameter int FIFO_DEPTH = srbp_pkg::FIFO_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [srbp_pkg::OP_W-1:0]      req_op,
   input  logic [srbp_pkg::BYTE_W-1:0]    req_data_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [srbp_pkg::BYTE_W-1:0]    rsp_data_out,
   output logic                           rsp_data_valid,
   output logic                           rsp_accepted,
   output logic [srbp_pkg::COUNT_W-1:0]   rsp_rx_count,
   output logic                           rsp_tx_irq_enable,
   // tx_enabled register
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data
);
   import srbp_pkg::*;

   cmd_type cmd;

   // sequencer: idle -> execute -> load
   srbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // pointers, stores, response register
   srbp_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_data_in       (req_data_in),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_data_out      (rsp_data_out),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_rx_count      (rsp_rx_count),
      .rsp_tx_irq_enable (rsp_tx_irq_enable)
   );

endmodule

FILE: rtl/srbp_ctrl.sv
`include "assert_macros.svh"

module srbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srbp_pkg::cmd_type cmd
);
   import srbp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_LOAD) && out_free);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = take;
      cmd.execute = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = take ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_exec_then_load, clock, reset, state_ff == S_EXEC, state_ff == S_LOAD)
   `ASSERT_IMPLIES(a_load_needs_room, clock, reset, cmd.load, !rsp_valid_ff || rsp_ready)

endmodule

FILE: rtl/srbp_datapath.sv
`include "assert_macros.svh"

module srbp_datapath #(
   parameter int FIFO_DEPTH = srbp_pkg::FIFO_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  srbp_pkg::cmd_type              cmd,
   input  logic [srbp_pkg::OP_W-1:0]      req_op,
   input  logic [srbp_pkg::BYTE_W-1:0]    req_data_in,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   output logic [srbp_pkg::BYTE_W-1:0]    rsp_data_out,
   output logic                           rsp_data_valid,
   output logic                           rsp_accepted,
   output logic [srbp_pkg::COUNT_W-1:0]   rsp_rx_count,
   output logic                           rsp_tx_irq_enable
);
   import srbp_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   // request word
   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] data_in_ff;

   logic tx_enabled_ff;

   // ring pointers and irq flag
   logic [PTR_W-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [PTR_W-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic             irq_ff, irq_in;
   logic [PTR_W-1:0] rx_wr_nxt, tx_wr_nxt;
   logic             rx_full, rx_empty, tx_full, tx_empty;
   logic             rx_we, tx_we;

   logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] rx_rd_data_ff, tx_rd_data_ff;

   // per-operation result flags
   logic res_valid_ff, res_valid_in;
   logic res_acc_ff, res_acc_in;
   logic res_tx_ff, res_tx_in;

   // response register
   logic [BYTE_W-1:0]        out_data_ff;
   logic                     out_valid_ff, out_acc_ff, out_irq_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic [PTR_W-1:0]         rx_fill;
   logic [PTR_W+COUNT_W-1:0] rx_fill_ext;

   // assertion terms
   logic exec_clear, exec_rx_push, ptrs_zero;

   assign rx_wr_nxt = rx_wr_ff + 1'b1;
   assign tx_wr_nxt = tx_wr_ff + 1'b1;
   assign rx_full   = (rx_wr_nxt == rx_rd_ff);
   assign tx_full   = (tx_wr_nxt == tx_rd_ff);
   assign rx_empty  = (rx_wr_ff == rx_rd_ff);
   assign tx_empty  = (tx_wr_ff == tx_rd_ff);

   always_comb begin
      rx_wr_in     = rx_wr_ff;
      rx_rd_in     = rx_rd_ff;
      tx_wr_in     = tx_wr_ff;
      tx_rd_in     = tx_rd_ff;
      irq_in       = irq_ff;
      rx_we        = 1'b0;
      tx_we        = 1'b0;
      res_valid_in = 1'b0;
      res_acc_in   = 1'b0;
      res_tx_in    = 1'b0;
      case (op_ff)
         OP_RX_PUSH: begin
            if (!rx_full) begin
               rx_we      = 1'b1;
               rx_wr_in   = rx_wr_nxt;
               res_acc_in = 1'b1;
            end
         end
         OP_RX_POP: begin
            if (!rx_empty) begin
               rx_rd_in     = rx_rd_ff + 1'b1;
               res_valid_in = 1'b1;
            end
         end
         OP_TX_PUSH: begin
            if (tx_enabled_ff) begin
               if (!tx_full) begin
                  tx_we      = 1'b1;
                  tx_wr_in   = tx_wr_nxt;
                  res_acc_in = 1'b1;
               end
               irq_in = 1'b1;
            end
         end
         OP_TX_POP: begin
            if (tx_empty) begin
               irq_in = 1'b0;
            end else begin
               tx_rd_in     = tx_rd_ff + 1'b1;
               res_valid_in = 1'b1;
               res_tx_in    = 1'b1;
            end
         end
         OP_CLEAR: begin
            rx_wr_in = '0;
            rx_rd_in = '0;
            tx_wr_in = '0;
            tx_rd_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff      <= '0;
         rx_rd_ff      <= '0;
         tx_wr_ff      <= '0;
         tx_rd_ff      <= '0;
         irq_ff        <= 1'b0;
         tx_enabled_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tx_enabled_ff <= csr_write_data;
         end
         if (cmd.execute) begin
            rx_wr_ff <= rx_wr_in;
            rx_rd_ff <= rx_rd_in;
            tx_wr_ff <= tx_wr_in;
            tx_rd_ff <= tx_rd_in;
            irq_ff   <= irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         data_in_ff <= req_data_in;
      end
      if (cmd.execute) begin
         res_valid_ff <= res_valid_in;
         res_acc_ff   <= res_acc_in;
         res_tx_ff    <= res_tx_in;
      end
   end

   // receive store
   always_ff @(posedge clock) begin
      if (cmd.execute && rx_we) begin
         rx_mem[rx_wr_ff] <= data_in_ff;
      end
      if (cmd.execute) begin
         rx_rd_data_ff <= rx_mem[rx_rd_ff];
      end
   end

   // transmit store
   always_ff @(posedge clock) begin
      if (cmd.execute && tx_we) begin
         tx_mem[tx_wr_ff] <= data_in_ff;
      end
      if (cmd.execute) begin
         tx_rd_data_ff <= tx_mem[tx_rd_ff];
      end
   end

   assign rx_fill     = rx_wr_ff - rx_rd_ff;
   assign rx_fill_ext = {{COUNT_W{1'b0}}, rx_fill};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_data_ff  <= res_valid_ff ? (res_tx_ff ? tx_rd_data_ff : rx_rd_data_ff) : '0;
         out_valid_ff <= res_valid_ff;
         out_acc_ff   <= res_acc_ff;
         out_count_ff <= rx_fill_ext[COUNT_W-1:0];
         out_irq_ff   <= irq_ff;
      end
   end

   assign rsp_data_out      = out_data_ff;
   assign rsp_data_valid    = out_valid_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_rx_count      = out_count_ff;
   assign rsp_tx_irq_enable = out_irq_ff;

   assign exec_clear   = cmd.execute && (op_ff == OP_CLEAR);
   assign exec_rx_push = cmd.execute && (op_ff == OP_RX_PUSH) && !rx_full;
   assign ptrs_zero    = (rx_wr_ff == '0) && (rx_rd_ff == '0) &&
                         (tx_wr_ff == '0) && (tx_rd_ff == '0);

   `ASSERT_NEXT(a_clear_zeroes_ptrs, clock, reset, exec_clear, ptrs_zero)
   `ASSERT_NEXT(a_rx_push_advances, clock, reset, exec_rx_push, rx_wr_ff == $past(rx_wr_nxt))

endmodule
